// ===== hdl/dfhe_pkg.sv =====
// Shared types, code tables and helpers for the fixed-Huffman DEFLATE encoder.
// No dependencies; imported by dfhe_encode, the top level and the test modules.
package dfhe_pkg;

  // Token kinds as carried on the input tuser
  localparam logic [1:0] FUNC_LIT   = 2'd0;
  localparam logic [1:0] FUNC_MATCH = 2'd1;
  localparam logic [1:0] FUNC_EOB   = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  localparam logic [8:0] EOB_SYMBOL          = 9'd256;
  localparam logic [8:0] FIRST_LENGTH_SYMBOL = 9'd257;

  localparam int LEN_CODES  = 29;
  localparam int DIST_CODES = 30;

  localparam logic [8:0] LEN_BASE [LEN_CODES] = '{
    9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
    9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
    9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
  };
  localparam logic [2:0] LEN_EXTRA [LEN_CODES] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd0
  };
  localparam logic [15:0] DIST_START [DIST_CODES] = '{
    16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
    16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385, 16'd513,
    16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097, 16'd6145,
    16'd8193, 16'd12289, 16'd16385, 16'd24577
  };
  localparam logic [3:0] DIST_EXTRA [DIST_CODES] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
    4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
  };

  // Registered token, with header request and range check already resolved
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  literal_byte;
    logic [8:0]  match_length;
    logic [15:0] match_distance;
    logic        final_block;
    logic        hdr;
    logic        bad;
  } tok_t;

  typedef struct packed {
    logic [33:0] chunk_bits;
    logic [5:0]  chunk_len;
    logic        align_after;
    logic        bad_token;
  } res_t;

  typedef struct packed {
    logic [8:0] code;  // already bit-reversed, LSB sent first
    logic [3:0] n;
  } hcode_t;

  function automatic logic token_bad(input logic [1:0] func,
                                     input logic [8:0] mlen,
                                     input logic [15:0] mdist);
    token_bad = (func == FUNC_MATCH) &&
                ((mlen < 9'd3) || (mlen > 9'd258) ||
                 (mdist == 16'd0) || (mdist > 16'd32768));
  endfunction

  // Fixed literal/length code, reversed for LSB-first output
  function automatic hcode_t litlen_code(input logic [8:0] sym);
    hcode_t     h;
    logic [8:0] c;
    logic [8:0] r;
    if (sym <= 9'd143) begin
      c = 9'h030 + sym;
      h.n = 4'd8;
    end else if (sym <= 9'd255) begin
      c = 9'h190 + (sym - 9'd144);
      h.n = 4'd9;
    end else if (sym <= 9'd279) begin
      c = sym - 9'd256;
      h.n = 4'd7;
    end else begin
      c = 9'h0C0 + {6'd0, sym[2:0]};
      h.n = 4'd8;
    end
    for (int i = 0; i < 9; i++) begin
      r[i] = c[8 - i];
    end
    h.code = r >> (4'd9 - h.n);
    return h;
  endfunction

endpackage

// ===== hdl/dfhe_encode.sv =====
// Combinational token coder: header, fixed litlen code, length/distance codes
// and extra bits packed LSB first. Depends on dfhe_pkg.
module dfhe_encode (
  input  dfhe_pkg::tok_t tok,
  output dfhe_pkg::res_t res
);
  import dfhe_pkg::*;

  logic [33:0] acc;
  logic [5:0]  pos;
  logic [4:0]  li;
  logic [4:0]  di;
  logic [8:0]  sym;
  hcode_t      hc;
  logic [8:0]  len_x;
  logic [15:0] dist_x;
  logic [4:0]  dcode_r;
  logic        live;

  // code index lookups: last base not above the value
  always_comb begin
    li = '0;
    for (int i = 0; i < LEN_CODES; i++) begin
      if (tok.match_length >= LEN_BASE[i]) li = 5'(i);
    end
    di = '0;
    for (int j = 0; j < DIST_CODES; j++) begin
      if (tok.match_distance >= DIST_START[j]) di = 5'(j);
    end
  end

  always_comb begin
    live    = (tok.func != FUNC_NONE) && !tok.bad;
    case (tok.func)
      FUNC_MATCH: sym = FIRST_LENGTH_SYMBOL + {4'd0, li};
      FUNC_EOB:   sym = EOB_SYMBOL;
      default:    sym = {1'b0, tok.literal_byte};
    endcase
    hc      = litlen_code(sym);
    len_x   = tok.match_length - LEN_BASE[li];
    dist_x  = tok.match_distance - DIST_START[di];
    dcode_r = {di[0], di[1], di[2], di[3], di[4]};

    acc = '0;
    pos = '0;
    if (live) begin
      if (tok.hdr) begin
        acc[2:0] = {1'b0, 1'b1, tok.final_block};  // BFINAL, then BTYPE=01
        pos      = 6'd3;
      end
      acc = acc | (34'(hc.code) << pos);
      pos = pos + 6'(hc.n);
      if (tok.func == FUNC_MATCH) begin
        acc = acc | (34'(len_x) << pos);
        pos = pos + 6'(LEN_EXTRA[li]);
        acc = acc | (34'(dcode_r) << pos);
        pos = pos + 6'd5;
        acc = acc | (34'(dist_x) << pos);
        pos = pos + 6'(DIST_EXTRA[di]);
      end
    end

    res.chunk_bits  = acc;
    res.chunk_len   = pos;
    res.align_after = live && (tok.func == FUNC_EOB) && tok.final_block;
    res.bad_token   = tok.bad;
  end

endmodule

// ===== hdl/deflate_fixed_huffman_encoder.sv =====
// Fixed-Huffman DEFLATE token encoder, top level: input register, coder,
// result register and block-open tracking. Depends on dfhe_pkg, dfhe_encode.
//
//  channel | dir | tdata (LSB up)                              | tuser      | tlast
//  --------+-----+---------------------------------------------+------------+------------
//  s_*     | in  | literal_byte 8, match_length 9,             | func 2     | -
//          |     | match_distance 16, final_block 1 (34 used)  |            |
//  m_*     | out | chunk_bits 34, chunk_len 6 (40 bits)        | bad_token  | align_after
//
// One item per cycle sustained while the output is not stalled; each item passes
// the input register, then the coder into the result register. The coder is one
// pass of table lookups and shifts. Block-open state updates as each item is
// accepted, so the next item may follow at once. Reset (rst, synchronous) empties
// both registers and marks no block open. A stalled output holds its item while one
// more item waits in the input register; s_tready drops only when both are full.
module deflate_fixed_huffman_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // literal_byte, match_length, match_distance, final_block
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // chunk_bits, chunk_len
  output logic        m_tlast,   // align_after
  output logic [0:0]  m_tuser    // bad_token
);
  import dfhe_pkg::*;

  logic   inside_block;
  logic   inside_block_next;
  logic   v1;
  tok_t   tok;
  tok_t   tok_next;
  res_t   enc;
  res_t   res;
  logic   s_acc;
  logic   adv;

  assign s_acc    = s_tvalid && s_tready;
  assign adv      = v1 && (!m_tvalid || m_tready);
  assign s_tready = !v1 || !m_tvalid || m_tready;

  // Unpack and pre-resolve the token
  always_comb begin
    tok_next.func           = s_tuser;
    tok_next.literal_byte   = s_tdata[7:0];
    tok_next.match_length   = s_tdata[16:8];
    tok_next.match_distance = s_tdata[32:17];
    tok_next.final_block    = s_tdata[33];
    tok_next.hdr            = !inside_block;
    tok_next.bad            = token_bad(s_tuser, s_tdata[16:8], s_tdata[32:17]);

    // Ignored and bad tokens leave the block state alone
    inside_block_next = inside_block;
    if (s_tuser != FUNC_NONE && !tok_next.bad) begin
      inside_block_next = (s_tuser != FUNC_EOB);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_block <= 1'b0;
      v1           <= 1'b0;
    end else if (s_acc) begin
      inside_block <= inside_block_next;
      v1           <= 1'b1;
    end else if (adv) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      tok <= tok_next;
    end
  end

  dfhe_encode u_encode (
    .tok (tok),
    .res (enc)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= enc;
    end
  end

  assign m_tdata    = {res.chunk_len, res.chunk_bits};
  assign m_tlast    = res.align_after;
  assign m_tuser[0] = res.bad_token;

endmodule

// ===== hdl/dfhe_checker.sv =====
// Port-level checks for the fixed-Huffman DEFLATE encoder, bound to the top.
// Depends only on the top level's ports.
module dfhe_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast,
  input logic [0:0]  m_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("result changed while stalled");

  // bad token carries no bits and no alignment
  a_bad_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[39:34] == 6'd0 && !m_tlast)
    else $error("bad token with payload");

  // alignment only after an end-of-block code, with or without header
  a_align_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[39:34] == 6'd7 || m_tdata[39:34] == 6'd10)
    else $error("align on a chunk that is not end of block");

  // bits above the length are zero
  a_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[33:0] >> m_tdata[39:34]) == 34'd0
      && m_tdata[39:34] <= 6'd34)
    else $error("stray chunk bits");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind deflate_fixed_huffman_encoder dfhe_checker u_dfhe_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ===== test/deflate_chunk_checker.sv =====
// Watches both streams of the fixed-Huffman DEFLATE encoder, predicts each chunk
// from the accepted tokens and compares it field by field. Depends on dfhe_pkg.
module deflate_chunk_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // literal_byte, match_length, match_distance, final_block
  input  logic [1:0]  s_tuser,   // func
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // chunk_bits, chunk_len
  input  logic        m_tlast,   // align_after
  input  logic [0:0]  m_tuser,   // bad_token
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import dfhe_pkg::*;

  typedef struct packed {
    logic [33:0] bits;
    logic [5:0]  len;
    logic        align;
    logic        bad;
  } chunk_t;

  chunk_t      expected_chunks[$];
  chunk_t      want;
  chunk_t      got;
  logic        block_open;

  // scratch for the bit packer
  logic [63:0] acc;
  int unsigned pos;

  function automatic logic [31:0] flip(input logic [31:0] v, input int unsigned n);
    logic [31:0] r;
    r = '0;
    for (int unsigned i = 0; i < n; i++) begin
      r[i] = v[n - 1 - i];
    end
    return r;
  endfunction

  function automatic void append_bits(input logic [31:0] val, input int unsigned n);
    if (n != 0) begin
      acc = acc | ((64'(val) & ((64'd1 << n) - 64'd1)) << pos);
      pos = pos + n;
    end
  endfunction

  // Fixed literal/length code, MSB of the code goes out first
  function automatic void append_litlen(input int unsigned sym);
    int unsigned c;
    int unsigned n;
    if (sym <= 143) begin
      c = 'h30 + sym;
      n = 8;
    end else if (sym <= 255) begin
      c = 'h190 + sym - 144;
      n = 9;
    end else if (sym <= 279) begin
      c = sym - 256;
      n = 7;
    end else begin
      c = 'hC0 + sym - 280;
      n = 8;
    end
    append_bits(flip(c, n), n);
  endfunction

  function automatic int unsigned len_extra_of(input int unsigned i);
    return (i >= 8 && i < 28) ? (i - 4) / 4 : 0;
  endfunction

  function automatic int unsigned dist_extra_of(input int unsigned i);
    return (i < 4) ? 0 : i / 2 - 1;
  endfunction

  function automatic chunk_t code_token(input logic [1:0] kind, input logic [7:0] lit,
                                        input logic [8:0] mlen, input logic [15:0] mdist,
                                        input logic fin);
    chunk_t      r;
    int unsigned li;
    int unsigned lb;
    int unsigned di;
    int unsigned db;
    int unsigned b;
    r   = '0;
    acc = '0;
    pos = 0;
    if (kind == FUNC_NONE) begin
      // ignored: all zero, state kept
    end else if (kind == FUNC_MATCH &&
                 (mlen < 3 || mlen > 258 || mdist == 0 || mdist > 32768)) begin
      r.bad = 1'b1;
    end else begin
      if (!block_open) begin
        append_bits(32'(fin) | 32'd2, 3);
        block_open = 1'b1;
      end
      if (kind == FUNC_LIT) begin
        append_litlen(lit);
      end else if (kind == FUNC_MATCH) begin
        li = 0; lb = 3; b = 3;
        for (int unsigned i = 0; i < 28; i++) begin
          if (b <= mlen) begin
            li = i;
            lb = b;
          end
          b = b + (1 << len_extra_of(i));
        end
        // 258 has a code of its own with no extra bits
        if (mlen == 258) begin
          li = 28;
          lb = 258;
        end
        di = 0; db = 1; b = 1;
        for (int unsigned i = 0; i < 30; i++) begin
          if (b <= mdist) begin
            di = i;
            db = b;
          end
          b = b + (1 << dist_extra_of(i));
        end
        append_litlen(257 + li);
        append_bits(mlen - lb, len_extra_of(li));
        append_bits(flip(di, 5), 5);
        append_bits(mdist - db, dist_extra_of(di));
      end else begin
        append_litlen(256);
        r.align    = fin;
        block_open = 1'b0;
      end
    end
    r.bits = acc[33:0];
    r.len  = 6'(pos);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      expected_chunks.delete();
      block_open = 1'b0;
      pending    = 0;
      fail_count = 0;
    end else begin
      // output first: a token taken at this edge cannot be answered at it
      if (m_tvalid && m_tready) begin
        got = {m_tdata[33:0], m_tdata[39:34], m_tlast, m_tuser[0]};
        if (expected_chunks.size() == 0) begin
          $error("chunk with no token waiting: bits %h len %0d", got.bits, got.len);
          fail_count++;
        end else begin
          want = expected_chunks.pop_front();
          if (got.bits !== want.bits) begin
            $error("chunk_bits: expected %h, got %h", want.bits, got.bits);
            fail_count++;
          end
          if (got.len !== want.len) begin
            $error("chunk_len: expected %0d, got %0d", want.len, got.len);
            fail_count++;
          end
          if (got.align !== want.align) begin
            $error("align_after: expected %b, got %b", want.align, got.align);
            fail_count++;
          end
          if (got.bad !== want.bad) begin
            $error("bad_token: expected %b, got %b", want.bad, got.bad);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_chunks.push_back(code_token(s_tuser, s_tdata[7:0], s_tdata[16:8],
                                             s_tdata[32:17], s_tdata[33]));
      end
      pending = expected_chunks.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the encoder test: clock, reset, token stimulus and output back-pressure.
// Depends on dfhe_pkg, deflate_fixed_huffman_encoder and deflate_chunk_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dfhe_pkg::*;

  // allow about ten times the slowest honest run of roughly 1100 items
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;    // literal_byte, match_length, match_distance, final_block
  logic [1:0]  s_tuser;    // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;    // chunk_bits, chunk_len
  logic        m_tlast;    // align_after
  logic [0:0]  m_tuser;    // bad_token

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          tokens_sent = 0;
  bit          calm_phase = 1'b0;  // no idling on either side while set
  bit          m_took = 1'b0;
  int          m_wait = 0;

  // main loop scratch
  int          run_len;
  int          pick;
  int          k;
  logic [8:0]  rlen;
  logic [15:0] rdist;

  deflate_fixed_huffman_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  deflate_chunk_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("deflate_fixed_huffman_encoder verification failed");
      $finish;
    end
  end

  // Gap drawn before an item: none in a calm phase, else often none, else a uniform random draw
  function automatic int draw_gap();
    if (calm_phase) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Output back-pressure: after each accepted chunk, hold tready low for a
  // freshly drawn number of cycles. Changes only on the falling edge.
  always @(posedge clk) m_took <= m_tvalid && m_tready;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      m_wait = 0;
    end else begin
      if (m_took) m_wait = draw_gap();
      if (m_wait > 0) begin
        m_tready <= 1'b0;
        m_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one token and return at the edge where it is taken. tvalid is only
  // lowered when a gap is drawn, so back-to-back items keep it high.
  task automatic send_token(input logic [1:0] kind, input logic [7:0] lit,
                            input logic [8:0] mlen, input logic [15:0] mdist,
                            input logic fin);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {6'd0, fin, mdist, mlen, lit};
    s_tuser  <= kind;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tokens_sent++;
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = FUNC_LIT;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: code-range edges, block opening on each kind, bad matches,
    // the ignored kind, empty blocks and the final end of block.
    send_token(FUNC_LIT,   8'd0,   9'd0,   16'd0,     1'b0);  // opens block
    send_token(FUNC_LIT,   8'd143, 9'h1FF, 16'hFFFF,  1'b1);
    send_token(FUNC_LIT,   8'd144, 9'd0,   16'd0,     1'b0);
    send_token(FUNC_LIT,   8'd255, 9'd0,   16'd0,     1'b0);
    send_token(FUNC_MATCH, 8'd0,   9'd3,   16'd1,     1'b0);
    send_token(FUNC_MATCH, 8'hFF,  9'd258, 16'd32768, 1'b0);  // length 258, top distance
    send_token(FUNC_MATCH, 8'd0,   9'd257, 16'd24577, 1'b0);
    send_token(FUNC_MATCH, 8'd0,   9'd10,  16'd4,     1'b0);
    send_token(FUNC_MATCH, 8'd0,   9'd11,  16'd5,     1'b0);
    send_token(FUNC_MATCH, 8'd0,   9'd227, 16'd16385, 1'b0);
    send_token(FUNC_MATCH, 8'd0,   9'd2,   16'd1,     1'b0);  // length too short
    send_token(FUNC_MATCH, 8'd0,   9'd259, 16'd1,     1'b0);  // length too long
    send_token(FUNC_MATCH, 8'd0,   9'h1FF, 16'hFFFF,  1'b1);
    send_token(FUNC_MATCH, 8'd0,   9'd3,   16'd0,     1'b0);  // zero distance
    send_token(FUNC_MATCH, 8'd0,   9'd3,   16'd32769, 1'b0);  // distance too far
    send_token(FUNC_NONE,  8'hFF,  9'h1FF, 16'hFFFF,  1'b1);  // ignored kind
    send_token(FUNC_EOB,   8'd0,   9'd0,   16'd0,     1'b0);  // close, no padding
    send_token(FUNC_EOB,   8'd0,   9'd0,   16'd0,     1'b0);  // empty block
    send_token(FUNC_MATCH, 8'd0,   9'd35,  16'd257,   1'b1);  // match opens final block
    send_token(FUNC_EOB,   8'd0,   9'd0,   16'd0,     1'b1);  // final close, pad
    send_token(FUNC_EOB,   8'd0,   9'd0,   16'd0,     1'b1);  // empty final block
    send_token(FUNC_NONE,  8'd0,   9'd0,   16'd0,     1'b0);  // ignored outside a block
    send_token(FUNC_LIT,   8'hA5,  9'd0,   16'd0,     1'b1);
    send_token(FUNC_EOB,   8'd0,   9'd0,   16'd0,     1'b0);

    // Random: mostly well-formed blocks of literals and matches closed by an
    // end of block, with bad matches and ignored items mixed in as noise.
    while (tokens_sent < 1000) begin
      run_len = $urandom_range(1, 24);
      for (int i = 0; i < run_len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          send_token(FUNC_LIT, 8'($urandom), 9'($urandom), 16'($urandom), 1'($urandom));
        end else if (pick < 88) begin
          rlen = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(3, 10))
                                             : 9'($urandom_range(3, 258));
          // pick a distance bucket first so every distance code turns up
          k     = $urandom_range(0, 15);
          rdist = 16'(1 + ($urandom & ((1 << k) - 1)));
          send_token(FUNC_MATCH, 8'($urandom), rlen, rdist, 1'($urandom));
        end else if (pick < 94) begin
          rlen  = 9'($urandom_range(3, 258));
          rdist = 16'($urandom_range(1, 32768));
          case ($urandom_range(0, 3))
            0: rlen  = 9'($urandom_range(0, 2));
            1: rlen  = 9'($urandom_range(259, 511));
            2: rdist = 16'd0;
            default: rdist = 16'($urandom_range(32769, 65535));
          endcase
          send_token(FUNC_MATCH, 8'($urandom), rlen, rdist, 1'($urandom));
        end else begin
          send_token(FUNC_NONE, 8'($urandom), 9'($urandom), 16'($urandom), 1'($urandom));
        end
      end
      send_token(FUNC_EOB, 8'($urandom), 9'($urandom), 16'($urandom), 1'($urandom));
      // now and then an empty block straight after
      if ($urandom_range(0, 9) == 0) begin
        send_token(FUNC_EOB, 8'($urandom), 9'($urandom), 16'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 5) == 0) calm_phase = ~calm_phase;
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    calm_phase = 1'b0;
    while (pending != 0) @(negedge clk);
    // spare cycles after the last chunk catch any stray one
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("deflate_fixed_huffman_encoder verification clean");
    end else begin
      $display("deflate_fixed_huffman_encoder verification failed");
    end
    $finish;
  end

endmodule
